FILE: hdl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants
// Cell operation codes, comparison flags and status codes for the allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

  // kind field codes
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,    // take the new region (addr, size)
    CELL_LEFT,    // take lower neighbor's entry
    CELL_RIGHT,   // take upper neighbor's entry
    CELL_GROW,    // length += size
    CELL_JOIN,    // length += size + upper neighbor's length
    CELL_TRIM,    // base += size, length -= size
    CELL_FRONT    // base = addr, length += size
  } cell_op_t;

  typedef struct packed {
    logic fit;     // length >= size
    logic gt;      // base > addr
    logic eqend;   // base + length == addr
    logic eqbase;  // base == addr + size
    logic eqlen;   // length == size
  } cell_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CMP,
    S_PICK,
    S_APPLY
  } state_t;

endpackage

FILE: hdl/sfla_cell.sv
// ----------------------------------------------------------------------------
// sfla_cell: one table entry
// Holds one free region, compares it against the request and moves or
// edits it on command from the control.
// ----------------------------------------------------------------------------
module sfla_cell
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        cmp_en,
  input  cell_op_t    op,
  input  logic [31:0] req_addr,
  input  logic [31:0] req_size,
  input  logic [31:0] req_end,
  input  logic [31:0] left_base,
  input  logic [31:0] left_len,
  input  logic [31:0] right_base,
  input  logic [31:0] right_len,
  output logic [31:0] base,
  output logic [31:0] len,
  output cell_flags_t flags
);

  logic [31:0] base_r, base_nxt;
  logic [31:0] len_r, len_nxt;
  cell_flags_t flags_r, flags_nxt;

  always_comb begin
    flags_nxt.fit    = (len_r >= req_size);
    flags_nxt.gt     = (base_r > req_addr);
    flags_nxt.eqend  = ((base_r + len_r) == req_addr);
    flags_nxt.eqbase = (base_r == req_end);
    flags_nxt.eqlen  = (len_r == req_size);
  end

  always_comb begin
    base_nxt = base_r;
    len_nxt  = len_r;
    unique case (op)
      CELL_HOLD: ;
      CELL_LOAD: begin
        base_nxt = req_addr;
        len_nxt  = req_size;
      end
      CELL_LEFT: begin
        base_nxt = left_base;
        len_nxt  = left_len;
      end
      CELL_RIGHT: begin
        base_nxt = right_base;
        len_nxt  = right_len;
      end
      CELL_GROW:  len_nxt = len_r + req_size;
      CELL_JOIN:  len_nxt = len_r + req_size + right_len;
      CELL_TRIM: begin
        base_nxt = base_r + req_size;
        len_nxt  = len_r - req_size;
      end
      CELL_FRONT: begin
        base_nxt = req_addr;
        len_nxt  = len_r + req_size;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    len_r  <= len_nxt;
    if (cmp_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign base  = base_r;
  assign len   = len_r;
  assign flags = flags_r;

endmodule

FILE: hdl/sorted_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// sorted_free_list_allocator_unit: first-fit free-list allocator
// Sorted region table kept in a row of cells; allocate takes the first region
// that fits, free inserts in order and merges with its neighbors.
// ----------------------------------------------------------------------------
// Sequence: after the start beat a request passes through prep, compare, pick
//   and apply, then the result is registered and strobed.
// Flow: busy is high from the cycle after the start beat until the result
//   strobe cycle, in which a new start is taken; no request overlaps another.
// Reset: synchronous rst_n clears count, peak, totals, loss counters and the
//   page mode; region storage is not cleared (entries past the count are
//   never used). The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module sorted_free_list_allocator_unit
  import sfla_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_round_to_page,
  // request beat
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_size,
  // result beat
  output logic        out_valid,
  output logic [31:0] out_alloc_addr,
  output logic [1:0]  out_status,
  output logic [31:0] out_free_total,
  output logic [8:0]  out_entry_count,
  output logic [8:0]  out_peak_count,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_lost_bytes
);

  localparam int N  = TABLE_ENTRIES;
  localparam int CW = $clog2(N + 1);

  state_t state_r, state_nxt;

  logic          round_r;
  logic          kind_r;
  logic [31:0]   addr_r, size_r, end_r;
  logic [CW-1:0] count_r, peak_r;
  logic [31:0]   total_r, lost_cnt_r, lost_bytes_r;

  logic          out_valid_r;
  logic [31:0]   grant_out_r;
  logic [1:0]    status_r;

  // pick-stage decisions
  logic [N-1:0]  first_r;     // one-hot first fitting cell
  logic [N-1:0]  ge_r;        // cells at or above the first fit
  logic [N:0]    marker_r;    // one-hot sorted insert position
  logic [N-1:0]  after_r;     // cells at or above the insert position
  logic          found_r, zero_r, pm_r, nm_r;
  logic [31:0]   grant_r;

  logic [31:0]   cbase [N];
  logic [31:0]   clen  [N];
  cell_flags_t   cflag [N];
  cell_op_t      cop   [N];

  logic [N-1:0]  valid, fit_v, after_v, eqend_v, eqbase_v, eqlen_v;
  logic [N-1:0]  first_c, ge_c, after_c;
  logic [N:0]    marker_c;
  logic          pm_c, nm_c, zero_c;
  logic [31:0]   grant_c;
  logic          full;

  assign busy = (state_r != S_IDLE);
  assign full = (count_r == CW'(N));

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [31:0] lb, ll, rb, rl;
    if (i == 0) begin : g_lo
      assign lb = '0;
      assign ll = '0;
    end else begin : g_lm
      assign lb = cbase[i-1];
      assign ll = clen[i-1];
    end
    if (i == N - 1) begin : g_hi
      assign rb = '0;
      assign rl = '0;
    end else begin : g_hm
      assign rb = cbase[i+1];
      assign rl = clen[i+1];
    end

    sfla_cell u_cell (
      .clk        (clk),
      .cmp_en     (state_r == S_CMP),
      .op         (cop[i]),
      .req_addr   (addr_r),
      .req_size   (size_r),
      .req_end    (end_r),
      .left_base  (lb),
      .left_len   (ll),
      .right_base (rb),
      .right_len  (rl),
      .base       (cbase[i]),
      .len        (clen[i]),
      .flags      (cflag[i])
    );

    assign valid[i]    = (CW'(i) < count_r);
    assign fit_v[i]    = cflag[i].fit & valid[i];
    // "base > addr" over held entries; a trimmed base that wrapped can break
    // the order, so this is not always a suffix
    assign after_v[i]  = cflag[i].gt | ~valid[i];
    assign eqend_v[i]  = cflag[i].eqend & valid[i];
    assign eqbase_v[i] = cflag[i].eqbase & valid[i];
    assign eqlen_v[i]  = cflag[i].eqlen;
  end

  // --------------------------------------------------------------------------
  // Pick: first fit and insert position, both from registered cell flags
  // --------------------------------------------------------------------------
  always_comb begin
    first_c = fit_v & (~fit_v + N'(1));
    ge_c    = ~(first_c - N'(1));
    // insert point is the first cell above addr (or past the end)
    marker_c[N-1:0] = after_v & (~after_v + N'(1));
    marker_c[N]     = ~|after_v;
    after_c = ~(marker_c[N-1:0] - N'(1));
    pm_c   = |(marker_c[N:1] & eqend_v);
    nm_c   = |(marker_c[N-1:0] & eqbase_v);
    zero_c = |(first_c & eqlen_v);
    grant_c = '0;
    for (int i = 0; i < N; i++) begin
      grant_c = grant_c | (first_c[i] ? cbase[i] : 32'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Apply: per-cell commands
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cop[i] = CELL_HOLD;
      if (state_r == S_APPLY) begin
        if (kind_r == KIND_ALLOC) begin
          if (found_r && zero_r && ge_r[i]) begin
            cop[i] = CELL_RIGHT;       // emptied region closes up
          end else if (found_r && !zero_r && first_r[i]) begin
            cop[i] = CELL_TRIM;
          end
        end else begin
          if (pm_r && nm_r) begin
            if (marker_r[i+1]) begin
              cop[i] = CELL_JOIN;
            end else if (after_r[i]) begin
              cop[i] = CELL_RIGHT;
            end
          end else if (pm_r) begin
            if (marker_r[i+1]) begin
              cop[i] = CELL_GROW;
            end
          end else if (nm_r) begin
            if (marker_r[i]) begin
              cop[i] = CELL_FRONT;
            end
          end else if (!full) begin
            if (marker_r[i]) begin
              cop[i] = CELL_LOAD;
            end else if (i > 0 && after_r[(i > 0) ? i - 1 : 0]) begin
              cop[i] = CELL_LEFT;     // open a gap at the insert point
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) begin
        state_nxt = S_PREP;
      end
      S_PREP:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture; page rounding done on the way in
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      kind_r <= in_kind;
      addr_r <= in_addr;
      size_r <= round_r ? ((in_size + PAGE_ADD) & PAGE_MASK) : in_size;
    end
    if (state_r == S_PREP) begin
      end_r <= addr_r + size_r;
    end
    if (state_r == S_PICK) begin
      first_r  <= first_c;
      ge_r     <= ge_c;
      marker_r <= marker_c;
      after_r  <= after_c;
      found_r  <= |fit_v;
      zero_r   <= zero_c;
      pm_r     <= pm_c;
      nm_r     <= nm_c;
      grant_r  <= grant_c;
    end
  end

  // statistics and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r      <= 1'b0;
      count_r      <= '0;
      peak_r       <= '0;
      total_r      <= '0;
      lost_cnt_r   <= '0;
      lost_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        round_r <= cfg_round_to_page;
      end
      out_valid_r <= (state_r == S_APPLY);
      if (state_r == S_APPLY) begin
        grant_out_r <= '0;
        status_r    <= ST_OK;
        if (kind_r == KIND_ALLOC) begin
          if (found_r) begin
            grant_out_r <= grant_r;
            total_r     <= total_r - size_r;
            if (zero_r) begin
              count_r <= count_r - CW'(1);
            end
          end else begin
            status_r <= ST_NOFIT;
          end
        end else if (pm_r || nm_r) begin
          total_r <= total_r + size_r;
          if (pm_r && nm_r) begin
            count_r <= count_r - CW'(1);
          end
        end else if (!full) begin
          total_r <= total_r + size_r;
          count_r <= count_r + CW'(1);
          if (peak_r < count_r + CW'(1)) begin
            peak_r <= count_r + CW'(1);
          end
        end else begin
          status_r     <= ST_LOST;
          lost_cnt_r   <= lost_cnt_r + 32'd1;
          lost_bytes_r <= lost_bytes_r + size_r;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alloc_addr  = grant_out_r;
  assign out_status      = status_r;
  assign out_free_total  = total_r;
  assign out_entry_count = 9'(count_r);
  assign out_peak_count  = 9'(peak_r);
  assign out_lost_count  = lost_cnt_r;
  assign out_lost_bytes  = lost_bytes_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_APPLY))
    else $error("result strobe without apply step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("entry count beyond table size");

  a_peak_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("peak below current count");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule
